/* src/cgt_pkg.sv */
package cgt_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  typedef logic signed [35:0] ang_t;
  typedef logic signed [32:0] mop_t;
  typedef logic signed [65:0] prod_t;

  typedef enum logic [1:0] {
    REG_HDG  = 2'd0,
    REG_SPD  = 2'd1,
    REG_DIST = 2'd2,
    REG_TMO  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] hdg_thr;
    logic [15:0] spd_thr;
    logic [23:0] dist_thr;
    logic [15:0] tmo_thr;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic vec;
    ang_t x;
    ang_t y;
    ang_t z;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    ang_t x;
    ang_t y;
    ang_t z;
  } cordic_rsp_t;

  typedef struct packed {
    logic        start;
    logic [60:0] v;
  } sq_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] r;
  } sq_rsp_t;

  localparam logic [14:0] HDG_THR_RST  = 15'd400;
  localparam logic [15:0] SPD_THR_RST  = 16'd500;
  localparam logic [23:0] DIST_THR_RST = 24'd400;
  localparam logic [15:0] TMO_THR_RST  = 16'd900;

  localparam ang_t PI_Q30       = 36'sd3373259426;
  localparam ang_t HALF_PI_Q30  = 36'sd1686629713;
  localparam ang_t TWO_PI_Q30   = 36'sd6746518852;
  localparam ang_t GAIN_INV_Q30 = 36'sd652032874;

  localparam logic [63:0] UNIT_TO_RAD = 64'd33537127121;
  localparam int          URAD_SH     = 18;
  localparam logic [17:0] URAD_LO     = UNIT_TO_RAD[17:0];
  localparam logic [16:0] URAD_HI     = UNIT_TO_RAD[34:18];
  localparam mop_t        TWO_R_CM    = 33'sd1274200000;
  localparam logic [63:0] RND_Q30     = 64'd536870912;

  localparam int DEG_DIV     = 1000000;
  localparam int MIN_PER_DEG = 600000;
  // degrees = (raw * DEG_RECIP) >> DEG_SH, exact for any 28-bit raw value
  localparam mop_t        DEG_RECIP = 33'sd281474977;
  localparam int          DEG_SH    = 48;
  localparam logic [27:0] DEG_NET   = 28'(DEG_DIV - MIN_PER_DEG);

  localparam logic [60:0] SQ_ONE = 61'h1000_0000_0000_0000;

  localparam logic [15:0] HDG_MOD  = 16'd36000;
  localparam logic [15:0] HDG_HALF = 16'd18000;
  localparam int SPD_NUM = 463;
  localparam int SPD_DEN = 90;
  localparam int MS_US   = 1000;

  function automatic ang_t atan_q30(input logic [5:0] idx);
    ang_t res;
    if (idx < 6'd11) begin
      unique case (idx)
        6'd0:    res = 36'sd843314856;
        6'd1:    res = 36'sd497837829;
        6'd2:    res = 36'sd263043836;
        6'd3:    res = 36'sd133525158;
        6'd4:    res = 36'sd67021686;
        6'd5:    res = 36'sd33543515;
        6'd6:    res = 36'sd16775850;
        6'd7:    res = 36'sd8388437;
        6'd8:    res = 36'sd4194282;
        6'd9:    res = 36'sd2097149;
        default: res = 36'sd1048575;
      endcase
    end else if (idx <= 6'd30) begin
      res = (ang_t'(1) <<< (6'd30 - idx)) - ang_t'(1);
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

/* src/cam_generation_trigger.sv */
// channel  | ports                       | direction
// in       | in_valid / in_ready + fix   | word in: one GPS fix
// out      | out_valid / out_ready + flags | word out: send and four trigger flags
// cfg      | psel penable pwrite paddr pwdata prdata pready | threshold registers
//
// Invalid fix or first valid fix: the result goes from accept via EVAL straight to OUT.
// Other fixes also take the distance path, built on one shared CORDIC unit
// used five times, one bit-serial square root used twice, and a reciprocal
// multiply for the degree split of each coordinate.
// One fix in flight; in_ready is high only while idle. A stalled result holds.
// Reset is synchronous; thresholds return to their defaults, reference clears.
module cam_generation_trigger #(
  parameter int CORDIC_STEPS = cgt_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_fix_valid,
  input  logic [26:0] in_lat_raw,
  input  logic        in_lat_south,
  input  logic [27:0] in_lon_raw,
  input  logic        in_lon_west,
  input  logic [16:0] in_speed_knots,
  input  logic [15:0] in_heading_cdeg,
  input  logic [55:0] in_time_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_send,
  output logic        out_trig_heading,
  output logic        out_trig_speed,
  output logic        out_trig_distance,
  output logic        out_trig_timeout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_EVAL = 21'h000002,
    S_DIV  = 21'h000004,
    S_RAD1 = 21'h000008,
    S_RAD2 = 21'h000010,
    S_RAD3 = 21'h000020,
    S_SCGO = 21'h000040,
    S_SCW  = 21'h000080,
    S_CAB  = 21'h000100,
    S_S2   = 21'h000200,
    S_T1   = 21'h000400,
    S_T2   = 21'h000800,
    S_S1   = 21'h001000,
    S_SUM  = 21'h002000,
    S_SQGO = 21'h004000,
    S_SQW  = 21'h008000,
    S_VCGO = 21'h010000,
    S_VCW  = 21'h020000,
    S_DIST = 21'h040000,
    S_DCMP = 21'h080000,
    S_OUT  = 21'h100000
  } state_t;

  localparam logic DIV_LAST = 1'b1;
  localparam logic signed [63:0] A_MAX = 64'sd1 <<< 60;

  state_t state_r, state_nxt;

  cgt_pkg::cfg_t        cfg;
  cgt_pkg::cordic_req_t creq;
  cgt_pkg::cordic_rsp_t crsp;
  cgt_pkg::sq_req_t     sreq;
  cgt_pkg::sq_rsp_t     srsp;

  // latched fix
  logic        fv_r, ls_r, lw_r;
  logic [26:0] lat_r;
  logic [27:0] lon_r;
  logic [16:0] spd_r;
  logic [15:0] hdg_r;
  logic [55:0] t_r;

  // reference fix
  logic        ref_valid_r, ref_ls_r, ref_lw_r;
  logic [26:0] ref_lat_r;
  logic [27:0] ref_lon_r;
  logic [16:0] ref_spd_r;
  logic [15:0] ref_hdg_r;
  logic [55:0] ref_t_r;

  logic [1:0]  k_r;
  logic [27:0] rem_r;
  logic [8:0]  q_r;
  logic        dcnt_r;

  cgt_pkg::ang_t la_r, lb_r, oa_r, ob_r;
  cgt_pkg::ang_t s1_r, s2_r, ca_r, cb_r;
  cgt_pkg::mop_t cab_r, zc_r;
  cgt_pkg::prod_t p_r, p_sh30;
  logic signed [63:0] s2sq_r, acc_r, asum;
  logic [60:0] a_r;
  logic [30:0] ys_r, xs_r;

  logic th_r, ts_r, tt_r, td_r, send_r;
  logic out_valid_r, o_send_r, o_th_r, o_ts_r, o_td_r, o_tt_r;

  cgt_pkg::mop_t ma, mb;
  logic [1:0]  kdiv;
  logic [27:0] raw_sel, units;
  logic        neg_sel;
  logic [63:0] rsum, dsum;
  logic [33:0] rad;
  cgt_pkg::ang_t rad_s, dlat, dlon;

  logic [15:0] h1, h2, dh, dhw;
  logic [16:0] dv;
  logic [25:0] spd_lhs, spd_rhs, tmo_rhs;
  logic [55:0] dt;
  logic        hit_hdg, hit_spd, hit_tmo, hit_dist, out_free;

  cgt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cgt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  cgt_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .rsp   (srsp)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_send          = o_send_r;
  assign out_trig_heading  = o_th_r;
  assign out_trig_speed    = o_ts_r;
  assign out_trig_distance = o_td_r;
  assign out_trig_timeout  = o_tt_r;
  assign out_free          = !out_valid_r || out_ready;

  // heading, speed, elapsed time
  always_comb begin
    h1  = (hdg_r >= cgt_pkg::HDG_MOD) ? hdg_r - cgt_pkg::HDG_MOD : hdg_r;
    h2  = (ref_hdg_r >= cgt_pkg::HDG_MOD) ? ref_hdg_r - cgt_pkg::HDG_MOD : ref_hdg_r;
    dh  = (h1 >= h2) ? h1 - h2 : h2 - h1;
    dhw = (dh >= cgt_pkg::HDG_HALF) ? cgt_pkg::HDG_MOD - dh : dh;
    hit_hdg = dhw >= {1'b0, cfg.hdg_thr};
    dv  = (spd_r >= ref_spd_r) ? spd_r - ref_spd_r : ref_spd_r - spd_r;
    spd_lhs = 26'(dv) * 26'(cgt_pkg::SPD_NUM);
    spd_rhs = 26'(cfg.spd_thr) * 26'(cgt_pkg::SPD_DEN);
    hit_spd = spd_lhs >= spd_rhs;
    dt  = (t_r >= ref_t_r) ? t_r - ref_t_r : ref_t_r - t_r;
    tmo_rhs = 26'(cfg.tmo_thr) * 26'(cgt_pkg::MS_US);
    hit_tmo = dt >= 56'(tmo_rhs);
  end

  // coordinate select
  assign kdiv = (state_r == S_EVAL) ? 2'd0 : k_r + 2'd1;

  always_comb begin
    unique case (kdiv)
      2'd0: raw_sel = {1'b0, ref_lat_r};
      2'd1: raw_sel = {1'b0, lat_r};
      2'd2: raw_sel = ref_lon_r;
      2'd3: raw_sel = lon_r;
    endcase
    unique case (k_r)
      2'd0: neg_sel = ref_ls_r;
      2'd1: neg_sel = ls_r;
      2'd2: neg_sel = ref_lw_r;
      2'd3: neg_sel = lw_r;
    endcase
  end

  assign units  = rem_r - 28'(q_r) * cgt_pkg::DEG_NET;
  assign rsum   = {p_r[45:0], 18'b0} + acc_r + cgt_pkg::RND_Q30;
  assign rad    = rsum[63:30];
  assign rad_s  = neg_sel ? -$signed({2'b0, rad}) : $signed({2'b0, rad});
  assign p_sh30 = p_r >>> 30;
  assign asum   = acc_r + p_r[63:0];
  assign dsum   = p_r[63:0] + cgt_pkg::RND_Q30;
  assign hit_dist = dsum[63:30] >= 34'(cfg.dist_thr);
  assign dlat   = lb_r - la_r;
  assign dlon   = ob_r - oa_r;

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_DIV: begin
        ma = {5'b0, rem_r};
        mb = cgt_pkg::DEG_RECIP;
      end
      S_RAD1: begin
        ma = {5'b0, units};
        mb = {15'b0, cgt_pkg::URAD_LO};
      end
      S_RAD2: begin
        ma = {5'b0, units};
        mb = {16'b0, cgt_pkg::URAD_HI};
      end
      S_CAB: begin
        ma = ca_r[32:0];
        mb = cb_r[32:0];
      end
      S_S2: begin
        ma = s2_r[32:0];
        mb = s2_r[32:0];
      end
      S_T1: begin
        ma = p_sh30[32:0];
        mb = cab_r;
      end
      S_T2: begin
        ma = {3'b0, s2sq_r[29:0]};
        mb = cab_r;
      end
      S_S1: begin
        ma = s1_r[32:0];
        mb = s1_r[32:0];
      end
      S_DIST: begin
        ma = zc_r;
        mb = cgt_pkg::TWO_R_CM;
      end
      default: begin
      end
    endcase
  end

  // requests to the shared units
  always_comb begin
    creq.start = (state_r == S_SCGO) || (state_r == S_VCGO);
    creq.vec   = (state_r == S_VCGO);
    if (state_r == S_VCGO) begin
      creq.x = {5'b0, xs_r};
      creq.y = {5'b0, ys_r};
      creq.z = '0;
    end else begin
      creq.x = cgt_pkg::GAIN_INV_Q30;
      creq.y = '0;
      unique case (k_r)
        2'd0: creq.z = dlat >>> 1;
        2'd1: creq.z = dlon >>> 1;
        2'd2: creq.z = la_r;
        2'd3: creq.z = lb_r;
      endcase
    end
    sreq.start = (state_r == S_SQGO);
    sreq.v     = (k_r == 2'd0) ? a_r : cgt_pkg::SQ_ONE - a_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = (!fv_r || !ref_valid_r) ? S_OUT : S_DIV;
      S_DIV:  if (dcnt_r == DIV_LAST) state_nxt = S_RAD1;
      S_RAD1: state_nxt = S_RAD2;
      S_RAD2: state_nxt = S_RAD3;
      S_RAD3: state_nxt = (k_r == 2'd3) ? S_SCGO : S_DIV;
      S_SCGO: state_nxt = S_SCW;
      S_SCW:  if (crsp.done) state_nxt = (k_r == 2'd3) ? S_CAB : S_SCGO;
      S_CAB:  state_nxt = S_S2;
      S_S2:   state_nxt = S_T1;
      S_T1:   state_nxt = S_T2;
      S_T2:   state_nxt = S_S1;
      S_S1:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_SQGO;
      S_SQGO: state_nxt = S_SQW;
      S_SQW:  if (srsp.done) state_nxt = (k_r == 2'd1) ? S_VCGO : S_SQGO;
      S_VCGO: state_nxt = S_VCW;
      S_VCW:  if (crsp.done) state_nxt = S_DIST;
      S_DIST: state_nxt = S_DCMP;
      S_DCMP: state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ref_valid_r <= 1'b0;
      ref_lat_r   <= '0;
      ref_ls_r    <= 1'b0;
      ref_lon_r   <= '0;
      ref_lw_r    <= 1'b0;
      ref_spd_r   <= '0;
      ref_hdg_r   <= '0;
      ref_t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
        if (send_r) begin
          ref_valid_r <= 1'b1;
          ref_lat_r   <= lat_r;
          ref_ls_r    <= ls_r;
          ref_lon_r   <= lon_r;
          ref_lw_r    <= lw_r;
          ref_spd_r   <= spd_r;
          ref_hdg_r   <= hdg_r;
          ref_t_r     <= t_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    unique case (state_r)
      S_IDLE: begin
        fv_r  <= in_fix_valid;
        lat_r <= in_lat_raw;
        ls_r  <= in_lat_south;
        lon_r <= in_lon_raw;
        lw_r  <= in_lon_west;
        spd_r <= in_speed_knots;
        hdg_r <= in_heading_cdeg;
        t_r   <= in_time_us;
      end
      S_EVAL: begin
        td_r   <= 1'b0;
        k_r    <= 2'd0;
        rem_r  <= raw_sel;
        q_r    <= '0;
        dcnt_r <= 1'b0;
        if (!fv_r) begin
          th_r <= 1'b0; ts_r <= 1'b0; tt_r <= 1'b0; send_r <= 1'b0;
        end else if (!ref_valid_r) begin
          th_r <= 1'b0; ts_r <= 1'b0; tt_r <= 1'b0; send_r <= 1'b1;
        end else begin
          th_r <= hit_hdg; ts_r <= hit_spd; tt_r <= hit_tmo;
        end
      end
      S_DIV: begin
        if (dcnt_r == DIV_LAST) begin
          q_r <= p_r[cgt_pkg::DEG_SH +: 9];
        end
        dcnt_r <= dcnt_r + 1'b1;
      end
      S_RAD2: acc_r <= p_r[63:0];
      S_RAD3: begin
        unique case (k_r)
          2'd0: la_r <= rad_s;
          2'd1: lb_r <= rad_s;
          2'd2: oa_r <= rad_s;
          2'd3: ob_r <= rad_s;
        endcase
        k_r    <= k_r + 2'd1;
        rem_r  <= raw_sel;
        q_r    <= '0;
        dcnt_r <= 1'b0;
      end
      S_SCW: begin
        if (crsp.done) begin
          unique case (k_r)
            2'd0: s1_r <= crsp.y;
            2'd1: s2_r <= crsp.y;
            2'd2: ca_r <= crsp.x;
            2'd3: cb_r <= crsp.x;
          endcase
          k_r <= k_r + 2'd1;
        end
      end
      S_S2:  cab_r  <= p_sh30[32:0];
      S_T1:  s2sq_r <= p_r[63:0];
      S_T2:  acc_r  <= p_r[63:0];
      S_S1:  acc_r  <= acc_r + p_sh30[63:0];
      S_SUM: begin
        if (asum[63]) begin
          a_r <= '0;
        end else if (asum > A_MAX) begin
          a_r <= cgt_pkg::SQ_ONE;
        end else begin
          a_r <= asum[60:0];
        end
      end
      S_SQW: begin
        if (srsp.done) begin
          if (k_r == 2'd0) begin
            ys_r <= srsp.r;
          end else begin
            xs_r <= srsp.r;
          end
          k_r <= k_r + 2'd1;
        end
      end
      S_VCW: begin
        if (crsp.done) begin
          zc_r <= crsp.z[35] ? '0 : crsp.z[32:0];
        end
      end
      S_DCMP: begin
        td_r   <= hit_dist;
        send_r <= th_r | ts_r | tt_r | hit_dist;
      end
      S_OUT: begin
        if (out_free) begin
          o_send_r <= send_r;
          o_th_r   <= th_r;
          o_ts_r   <= ts_r;
          o_td_r   <= td_r;
          o_tt_r   <= tt_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/cgt_regs.sv */
module cgt_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cgt_pkg::cfg_t       cfg
);

  cgt_pkg::cfg_t     cfg_r;
  cgt_pkg::reg_idx_t idx;

  assign idx    = cgt_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdg_thr  <= cgt_pkg::HDG_THR_RST;
      cfg_r.spd_thr  <= cgt_pkg::SPD_THR_RST;
      cfg_r.dist_thr <= cgt_pkg::DIST_THR_RST;
      cfg_r.tmo_thr  <= cgt_pkg::TMO_THR_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        cgt_pkg::REG_HDG:  cfg_r.hdg_thr  <= pwdata[14:0];
        cgt_pkg::REG_SPD:  cfg_r.spd_thr  <= pwdata[15:0];
        cgt_pkg::REG_DIST: cfg_r.dist_thr <= pwdata[23:0];
        cgt_pkg::REG_TMO:  cfg_r.tmo_thr  <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cgt_pkg::REG_HDG:  prdata = 32'(cfg_r.hdg_thr);
      cgt_pkg::REG_SPD:  prdata = 32'(cfg_r.spd_thr);
      cgt_pkg::REG_DIST: prdata = 32'(cfg_r.dist_thr);
      cgt_pkg::REG_TMO:  prdata = 32'(cfg_r.tmo_thr);
    endcase
  end

endmodule

/* src/cgt_cordic.sv */
module cgt_cordic #(
  parameter int STEPS = cgt_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cgt_pkg::cordic_req_t req,
  output cgt_pkg::cordic_rsp_t rsp
);

  localparam int IW = $clog2(STEPS);

  typedef enum logic [4:0] {
    CS_IDLE = 5'b00001,
    CS_WRAP = 5'b00010,
    CS_FLIP = 5'b00100,
    CS_ITER = 5'b01000,
    CS_DONE = 5'b10000
  } cstate_t;

  cstate_t         state_r;
  cgt_pkg::ang_t   x_r, y_r, z_r;
  logic            vec_r, flip_r;
  logic [IW-1:0]   i_r;

  cgt_pkg::ang_t   dx, dy, at;
  logic            ccw;

  assign dx  = y_r >>> i_r;
  assign dy  = x_r >>> i_r;
  assign at  = cgt_pkg::atan_q30(6'(i_r));
  assign ccw = vec_r ? !(y_r > 0) : (z_r >= 0);

  assign rsp.done = (state_r == CS_DONE);
  assign rsp.x    = flip_r ? -x_r : x_r;
  assign rsp.y    = flip_r ? -y_r : y_r;
  assign rsp.z    = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      unique case (state_r)
        CS_IDLE: begin
          if (req.start) begin
            state_r <= req.vec ? CS_ITER : CS_WRAP;
          end
        end
        CS_WRAP: state_r <= CS_FLIP;
        CS_FLIP: state_r <= CS_ITER;
        CS_ITER: begin
          if (i_r == IW'(STEPS - 1)) begin
            state_r <= CS_DONE;
          end
        end
        CS_DONE: state_r <= CS_IDLE;
        default: state_r <= CS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      CS_IDLE: begin
        x_r    <= req.x;
        y_r    <= req.y;
        z_r    <= req.z;
        vec_r  <= req.vec;
        flip_r <= 1'b0;
        i_r    <= '0;
      end
      CS_WRAP: begin
        if (z_r > cgt_pkg::PI_Q30) begin
          z_r <= z_r - cgt_pkg::TWO_PI_Q30;
        end else if (z_r < -cgt_pkg::PI_Q30) begin
          z_r <= z_r + cgt_pkg::TWO_PI_Q30;
        end
      end
      CS_FLIP: begin
        if (z_r > cgt_pkg::HALF_PI_Q30) begin
          z_r    <= z_r - cgt_pkg::PI_Q30;
          flip_r <= 1'b1;
        end else if (z_r < -cgt_pkg::HALF_PI_Q30) begin
          z_r    <= z_r + cgt_pkg::PI_Q30;
          flip_r <= 1'b1;
        end
      end
      CS_ITER: begin
        if (ccw) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/cgt_isqrt.sv */
module cgt_isqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  cgt_pkg::sq_req_t req,
  output cgt_pkg::sq_rsp_t rsp
);

  typedef enum logic [2:0] {
    QS_IDLE = 3'b001,
    QS_RUN  = 3'b010,
    QS_DONE = 3'b100
  } qstate_t;

  qstate_t     state_r;
  logic [60:0] v_r;
  logic [61:0] r_r;
  logic [60:0] bit_r;
  logic [61:0] trial;

  assign trial    = r_r + 62'(bit_r);
  assign rsp.done = (state_r == QS_DONE);
  assign rsp.r    = r_r[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= QS_IDLE;
    end else begin
      unique case (state_r)
        QS_IDLE: if (req.start) state_r <= QS_RUN;
        QS_RUN:  if (bit_r[0]) state_r <= QS_DONE;
        QS_DONE: state_r <= QS_IDLE;
        default: state_r <= QS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      QS_IDLE: begin
        v_r   <= req.v;
        r_r   <= '0;
        bit_r <= cgt_pkg::SQ_ONE;
      end
      QS_RUN: begin
        if ({1'b0, v_r} >= trial) begin
          v_r <= v_r - trial[60:0];
          r_r <= (r_r >> 1) + 62'(bit_r);
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/cgt_checker.sv */
module cgt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_send,
  input logic out_trig_heading,
  input logic out_trig_speed,
  input logic out_trig_distance,
  input logic out_trig_timeout
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_send, out_trig_heading,
      out_trig_speed, out_trig_distance, out_trig_timeout}))
    else $error("result word changed while stalled");

  a_trig_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_trig_heading || out_trig_speed || out_trig_distance ||
      out_trig_timeout) |-> out_send)
    else $error("trigger without send");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a word");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result produced from idle");

endmodule

bind cam_generation_trigger cgt_checker u_cgt_checker (.*);

/* bench/tb_top.sv */
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS      = cgt_pkg::CORDIC_STEPS_DEF;
  localparam int STALL_MAX  = 6000;
  localparam int N_RANDOM   = 530;

  typedef struct {
    bit        fix_valid;
    bit [26:0] lat_raw;
    bit        lat_south;
    bit [27:0] lon_raw;
    bit        lon_west;
    bit [16:0] speed_knots;
    bit [15:0] heading_cdeg;
    bit [55:0] time_us;
  } fix_t;

  typedef struct {
    bit send;
    bit trig_heading;
    bit trig_speed;
    bit trig_distance;
    bit trig_timeout;
  } flags_t;

  class trigger_scoreboard;
    flags_t    pending[$];
    int        fails;
    bit [14:0] hdg_thr;
    bit [15:0] spd_thr;
    bit [23:0] dist_thr;
    bit [15:0] tmo_thr;
    bit        have_ref;
    fix_t      ref_fix;

    function new();
      hdg_thr  = cgt_pkg::HDG_THR_RST;
      spd_thr  = cgt_pkg::SPD_THR_RST;
      dist_thr = cgt_pkg::DIST_THR_RST;
      tmo_thr  = cgt_pkg::TMO_THR_RST;
      have_ref = 0;
      fails    = 0;
    endfunction

    function void set_threshold(cgt_pkg::reg_idx_t idx, bit [31:0] val);
      case (idx)
        cgt_pkg::REG_HDG:  hdg_thr  = val[14:0];
        cgt_pkg::REG_SPD:  spd_thr  = val[15:0];
        cgt_pkg::REG_DIST: dist_thr = val[23:0];
        cgt_pkg::REG_TMO:  tmo_thr  = val[15:0];
      endcase
    endfunction

    function longint arctan_step(int i);
      longint tbl[11] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                          33543515, 16775850, 8388437, 4194282, 2097149, 1048575};
      if (i < 11) return tbl[i];
      if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
      return 0;
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint coord_rad(longint unsigned raw, bit neg);
      longint unsigned units, q;
      units = (raw / 1000000) * 600000 + raw % 1000000;
      q = (units * 64'd33537127121 + (64'd1 << 29)) >> 30;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function void rotate(longint th, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit flip;
      x = 652032874;
      y = 0;
      flip = 0;
      while (th > 64'sd3373259426) th -= 64'sd6746518852;
      while (th < -64'sd3373259426) th += 64'sd6746518852;
      if (th > 64'sd1686629713) begin
        th -= 64'sd3373259426;
        flip = 1;
      end else if (th < -64'sd1686629713) begin
        th += 64'sd3373259426;
        flip = 1;
      end
      z = th;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_step(i);
        end else begin
          x += dx; y -= dy; z += arctan_step(i);
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function longint unsigned haversine_cm(fix_t f);
      longint la, lb, oa, ob, s1, s2, ca, cb, tmp, cab, s2sq, a, x, y, z, dx, dy;
      longint one2;
      one2 = 64'sd1 <<< 60;
      la = coord_rad(ref_fix.lat_raw, ref_fix.lat_south);
      lb = coord_rad(f.lat_raw, f.lat_south);
      oa = coord_rad(ref_fix.lon_raw, ref_fix.lon_west);
      ob = coord_rad(f.lon_raw, f.lon_west);
      rotate((lb - la) >>> 1, s1, tmp);
      rotate((ob - oa) >>> 1, s2, tmp);
      rotate(la, tmp, ca);
      rotate(lb, tmp, cb);
      cab = (ca * cb) >>> 30;
      s2sq = s2 * s2;
      a = s1 * s1 + (s2sq >>> 30) * cab + (((s2sq & ((64'sd1 <<< 30) - 1)) * cab) >>> 30);
      if (a < 0) a = 0;
      if (a > one2) a = one2;
      y = root64(a);
      x = root64(one2 - a);
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += arctan_step(i);
        end else begin
          x -= dx; y += dy; z -= arctan_step(i);
        end
      end
      if (z < 0) z = 0;
      return (z * 64'sd1274200000 + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function void note_fix(fix_t f);
      flags_t e;
      longint unsigned h1, h2, dh, dv, dt;
      e = '{default: 0};
      if (f.fix_valid) begin
        if (!have_ref) begin
          e.send = 1;
        end else begin
          h1 = f.heading_cdeg % 36000;
          h2 = ref_fix.heading_cdeg % 36000;
          dh = h1 >= h2 ? h1 - h2 : h2 - h1;
          if (dh >= 18000) dh = 36000 - dh;
          dv = f.speed_knots >= ref_fix.speed_knots ?
               f.speed_knots - ref_fix.speed_knots : ref_fix.speed_knots - f.speed_knots;
          dt = f.time_us >= ref_fix.time_us ?
               f.time_us - ref_fix.time_us : ref_fix.time_us - f.time_us;
          e.trig_heading  = dh >= hdg_thr;
          e.trig_speed    = dv * 463 >= longint'(spd_thr) * 90;
          e.trig_distance = haversine_cm(f) >= dist_thr;
          e.trig_timeout  = dt >= longint'(tmo_thr) * 1000;
          e.send = e.trig_heading | e.trig_speed | e.trig_distance | e.trig_timeout;
        end
        if (e.send) begin
          have_ref = 1;
          ref_fix = f;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_flags(flags_t got);
      flags_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        fails++;
        return;
      end
      e = pending.pop_front();
      if (got.send != e.send) begin
        $error("send exp %0d got %0d", e.send, got.send); fails++;
      end
      if (got.trig_heading != e.trig_heading) begin
        $error("trig_heading exp %0d got %0d", e.trig_heading, got.trig_heading); fails++;
      end
      if (got.trig_speed != e.trig_speed) begin
        $error("trig_speed exp %0d got %0d", e.trig_speed, got.trig_speed); fails++;
      end
      if (got.trig_distance != e.trig_distance) begin
        $error("trig_distance exp %0d got %0d", e.trig_distance, got.trig_distance); fails++;
      end
      if (got.trig_timeout != e.trig_timeout) begin
        $error("trig_timeout exp %0d got %0d", e.trig_timeout, got.trig_timeout); fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_fix_valid;
  logic [26:0] in_lat_raw;
  logic        in_lat_south;
  logic [27:0] in_lon_raw;
  logic        in_lon_west;
  logic [16:0] in_speed_knots;
  logic [15:0] in_heading_cdeg;
  logic [55:0] in_time_us;
  logic        out_valid;
  logic        out_ready;
  logic        out_send;
  logic        out_trig_heading;
  logic        out_trig_speed;
  logic        out_trig_distance;
  logic        out_trig_timeout;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  trigger_scoreboard sb;
  int   in_idle;
  int   out_idle;
  int   stall_cycles;
  fix_t track;

  cam_generation_trigger u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_fix_valid = 0;
    in_lat_raw = '0;
    in_lat_south = 0;
    in_lon_raw = '0;
    in_lon_west = 0;
    in_speed_knots = '0;
    in_heading_cdeg = '0;
    in_time_us = '0;
    out_ready = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_idle = 13;
    out_idle = 79;
    stall_cycles = 0;
    sb = new();
  end

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= out_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_fix(
          '{in_fix_valid, in_lat_raw, in_lat_south, in_lon_raw, in_lon_west,
            in_speed_knots, in_heading_cdeg, in_time_us});
      if (out_valid && out_ready) sb.check_flags(
          '{out_send, out_trig_heading, out_trig_speed, out_trig_distance,
            out_trig_timeout});
      if ((in_valid && in_ready) || (out_valid && out_ready) || !in_valid && sb.pending.size() == 0)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("cam_generation_trigger regression: fail");
        $finish;
      end
    end
  end

  task automatic push_fix(fix_t f);
    int gap;
    in_valid        <= 1;
    in_fix_valid    <= f.fix_valid;
    in_lat_raw      <= f.lat_raw;
    in_lat_south    <= f.lat_south;
    in_lon_raw      <= f.lon_raw;
    in_lon_west     <= f.lon_west;
    in_speed_knots  <= f.speed_knots;
    in_heading_cdeg <= f.heading_cdeg;
    in_time_us      <= f.time_us;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    while ($urandom_range(99) < in_idle && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_threshold(cgt_pkg::reg_idx_t idx, bit [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    sb.set_threshold(idx, val);
  endtask

  task automatic set_thresholds(bit [31:0] h, bit [31:0] s, bit [31:0] d, bit [31:0] t);
    write_threshold(cgt_pkg::REG_HDG, h);
    write_threshold(cgt_pkg::REG_SPD, s);
    write_threshold(cgt_pkg::REG_DIST, d);
    write_threshold(cgt_pkg::REG_TMO, t);
  endtask

  function automatic fix_t any_fix();
    fix_t f;
    f.fix_valid    = $urandom_range(9) != 0;
    f.lat_raw      = 27'($urandom_range(3) == 0 ? $urandom : $urandom_range(90000000));
    f.lat_south    = 1'($urandom_range(1));
    f.lon_raw      = 28'($urandom_range(3) == 0 ? $urandom : $urandom_range(180000000));
    f.lon_west     = 1'($urandom_range(1));
    f.speed_knots  = 17'($urandom_range(3) == 0 ? $urandom : $urandom_range(99999));
    f.heading_cdeg = 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(35999));
    f.time_us      = 56'({$urandom, $urandom});
    return f;
  endfunction

  function automatic fix_t next_on_track();
    track.fix_valid = $urandom_range(19) != 0;
    track.lat_raw = 27'(track.lat_raw + $urandom_range(400) - 200);
    track.lon_raw = 28'(track.lon_raw + $urandom_range(400) - 200);
    track.speed_knots = 17'(track.speed_knots + $urandom_range(200) - 100);
    track.heading_cdeg = 16'((track.heading_cdeg + 36000 + $urandom_range(800) - 400) % 36000);
    track.time_us = track.time_us + 56'($urandom_range(1200000));
    return track;
  endfunction

  function automatic fix_t mk(bit v, int unsigned la, bit s, int unsigned lo, bit w,
                              int unsigned sp, int unsigned hd, bit [55:0] t);
    fix_t f;
    f = '{v, 27'(la), s, 28'(lo), w, 17'(sp), 16'(hd), t};
    return f;
  endfunction

  initial begin
    fix_t f;
    #1;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    push_fix(mk(0, 45000000, 0, 9000000, 0, 1000, 100, 0));
    push_fix(mk(1, 45000000, 0, 9000000, 0, 1000, 35900, 1000000));
    push_fix(mk(1, 45000000, 0, 9000000, 0, 1000, 100, 1100000));
    push_fix(mk(1, 45000000, 0, 9000000, 0, 1000, 350, 1200000));
    push_fix(mk(1, 45000000, 0, 9000000, 0, 1100, 350, 1300000));
    push_fix(mk(1, 45000000, 0, 9000000, 0, 1100, 350, 2300000));
    push_fix(mk(1, 45000200, 0, 9000000, 0, 1100, 350, 2400000));
    push_fix(mk(1, 45000200, 0, 9000000, 0, 1100, 36350, 2500000));
    push_fix(mk(1, 45000200, 0, 9000000, 0, 1100, 65535, 2600000));
    push_fix(mk(1, 4599999, 1, 9999999, 1, 0, 0, 2700000));
    push_fix(mk(1, 90000000, 0, 180000000, 0, 99999, 18000, 56'hFF_FFFF_FFFF_FFFF));
    push_fix(mk(1, 90000000, 1, 180000000, 1, 0, 0, 0));
    push_fix(mk(1, 134217727, 0, 268435455, 1, 131071, 35999, 5));
    push_fix(mk(1, 0, 0, 0, 0, 0, 17999, 10));
    push_fix(mk(1, 0, 1, 0, 1, 0, 0, 20));
    push_fix(mk(0, 134217727, 1, 268435455, 1, 131071, 65535, 56'hFF_FFFF_FFFF_FFFF));
    push_fix(mk(1, 0, 0, 179595959, 0, 0, 0, 30));
    push_fix(mk(1, 0, 0, 0, 1, 0, 0, 40));
    drain();

    track = mk(1, 48000000, 0, 11000000, 0, 3000, 9000, 1000000);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 106 == 0) begin
        drain();
        case (n / 106)
          0: set_thresholds(0, 0, 0, 0);
          1: set_thresholds(18000, 65535, 16777215, 65535);
          2: set_thresholds(32767, 500, 2000, 900);
          3: set_thresholds($urandom_range(1000), $urandom_range(2000),
                            $urandom_range(5000), $urandom_range(2000));
          default: set_thresholds(cgt_pkg::HDG_THR_RST, cgt_pkg::SPD_THR_RST,
                                  cgt_pkg::DIST_THR_RST, cgt_pkg::TMO_THR_RST);
        endcase
      end
      if (n == 180) begin
        in_idle = 79;
        out_idle = 13;
      end else if (n == 360) begin
        in_idle = 0;
        out_idle = 0;
      end
      if ($urandom_range(9) < 7) f = next_on_track();
      else f = any_fix();
      push_fix(f);
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.fails == 0)
      $display("cam_generation_trigger regression: pass");
    else
      $display("cam_generation_trigger regression: fail");
    $finish;
  end

endmodule
